// ----- rtl/core/periodic_and_oneshot_timer_table_unit_macros.svh -----
// Assertion macros shared by the timer table RTL.
`ifndef PERIODIC_AND_ONESHOT_TIMER_TABLE_UNIT_MACROS_SVH
`define PERIODIC_AND_ONESHOT_TIMER_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define POTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define POTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/pott_pkg.sv -----
// Package with command and status codes and sizes of the timer table.
package pott_pkg;

	// Default number of slots in the table.
	localparam int SLOTS_DEF = 16;

	// Field widths.
	localparam int CMD_W   = 3;
	localparam int ID_W    = 6;
	localparam int ARG_W   = 16;
	localparam int CNT_W   = 16;
	localparam int CLASS_W = 2;
	localparam int STAT_W  = 2;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_START_DAEMON = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START_FUSE   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_LENGTHEN     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CANCEL       = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RUN_DAEMONS  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_RUN_FUSES    = 3'd5;

	// Status codes.
	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

	// Result kinds.
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_FIRED  = 1'b1;

	// Special counts and classes.
	localparam logic [CNT_W-1:0]   DAEMON_COUNT = '1;
	localparam logic [CNT_W-1:0]   DEC_ONE      = '1;
	localparam logic [CLASS_W-1:0] CLASS_EMPTY  = '0;

endpackage

// ----- rtl/core/periodic_and_oneshot_timer_table_unit.sv -----
// Timer table: slot store, scanning sequencer, shared count adder and result register.
// Each scanning command visits the slots in order, each slot with a read step, then an evaluate and
// write-back step; start, lengthen and cancel stop at the first matching slot.
// Codes 6 and 7 skip the scan and go straight to the status beat.
// A fired beat that finds the result register full holds the scan until it drains.
// Reset (arst_n low) empties every slot and clears the sequencer and result valid; no sweep.
`include "periodic_and_oneshot_timer_table_unit_macros.svh"

module periodic_and_oneshot_timer_table_unit #(
	parameter int SLOTS = pott_pkg::SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [pott_pkg::CMD_W-1:0]         command,
	input  logic [pott_pkg::ID_W-1:0]          action_id,
	input  logic [pott_pkg::ARG_W-1:0]         action_arg,
	input  logic signed [pott_pkg::CNT_W-1:0]  turns,
	input  logic [pott_pkg::CLASS_W-1:0]       slot_class,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               result_kind,
	output logic [pott_pkg::STAT_W-1:0]        status,
	output logic [pott_pkg::ID_W-1:0]          fired_id,
	output logic [pott_pkg::ARG_W-1:0]         fired_arg,
	output logic                               last
);

	localparam int SLOT_W = $clog2(SLOTS);
	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);
	localparam int CNT_W = pott_pkg::CNT_W;

	// Sequencer state codes.
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_EV   = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [SLOT_W-1:0] idx_q;

	// Latched command.
	logic [pott_pkg::CMD_W-1:0]   cmd_q;
	logic [pott_pkg::ID_W-1:0]    id_q;
	logic [pott_pkg::ARG_W-1:0]   arg_q;
	logic [CNT_W-1:0]             turns_q;
	logic [pott_pkg::CLASS_W-1:0] cls_q;
	logic [pott_pkg::STAT_W-1:0]  stat_q;

	// Slot store.
	logic [pott_pkg::CLASS_W-1:0] class_q [SLOTS];
	logic [pott_pkg::ID_W-1:0]    id_mem  [SLOTS];
	logic [pott_pkg::ARG_W-1:0]   arg_mem [SLOTS];
	logic [CNT_W-1:0]             cnt_mem [SLOTS];

	// Slot read stage.
	logic [pott_pkg::CLASS_W-1:0] slot_cls_s1;
	logic [pott_pkg::ID_W-1:0]    slot_id_s1;
	logic [pott_pkg::ARG_W-1:0]   slot_arg_s1;
	logic [CNT_W-1:0]             slot_cnt_s1;

	// Result register.
	logic                         out_valid_q;
	logic                         out_kind_q;
	logic [pott_pkg::STAT_W-1:0]  out_stat_q;
	logic [pott_pkg::ID_W-1:0]    out_id_q;
	logic [pott_pkg::ARG_W-1:0]   out_arg_q;
	logic                         out_last_q;

	logic accept;
	logic out_free;
	logic hit;
	logic emit;
	logic go;
	logic wr_all;
	logic wr_cnt;
	logic clr_cls;
	logic sel_match;
	logic id_match;
	logic [CNT_W-1:0] add_b;
	logic [CNT_W:0]   sum;
	logic [CNT_W-1:0] new_cnt;
	logic [CNT_W-1:0] wr_cnt_val;
	logic [pott_pkg::STAT_W-1:0] miss_stat;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// Shared adder: adds turns for lengthen, minus one for fuse runs, then saturates.
	assign add_b = (cmd_q == pott_pkg::CMD_RUN_FUSES) ? pott_pkg::DEC_ONE : turns_q;
	assign sum   = {slot_cnt_s1[CNT_W-1], slot_cnt_s1} + {add_b[CNT_W-1], add_b};
	always_comb begin
		if (sum[CNT_W] != sum[CNT_W-1]) begin
			new_cnt = sum[CNT_W] ? {1'b1, {(CNT_W-1){1'b0}}} : {1'b0, {(CNT_W-1){1'b1}}};
		end else begin
			new_cnt = sum[CNT_W-1:0];
		end
	end

	assign sel_match = (cls_q != pott_pkg::CLASS_EMPTY) && (slot_cls_s1 == cls_q);
	assign id_match  = (slot_cls_s1 != pott_pkg::CLASS_EMPTY) && (slot_id_s1 == id_q);

	// Slot evaluation for the command in progress.
	always_comb begin
		hit        = 1'b0;
		emit       = 1'b0;
		wr_all     = 1'b0;
		wr_cnt     = 1'b0;
		clr_cls    = 1'b0;
		wr_cnt_val = new_cnt;
		miss_stat  = pott_pkg::STAT_OK;
		unique case (cmd_q) inside
			pott_pkg::CMD_START_DAEMON, pott_pkg::CMD_START_FUSE: begin
				hit        = (slot_cls_s1 == pott_pkg::CLASS_EMPTY);
				wr_all     = hit;
				wr_cnt_val = (cmd_q == pott_pkg::CMD_START_DAEMON) ?
					pott_pkg::DAEMON_COUNT : turns_q;
				miss_stat  = pott_pkg::STAT_FULL;
			end
			pott_pkg::CMD_LENGTHEN: begin
				hit       = id_match;
				wr_cnt    = hit;
				miss_stat = pott_pkg::STAT_NOT_FOUND;
			end
			pott_pkg::CMD_CANCEL: begin
				hit       = id_match;
				clr_cls   = hit;
				miss_stat = pott_pkg::STAT_NOT_FOUND;
			end
			pott_pkg::CMD_RUN_DAEMONS: begin
				emit = sel_match && (slot_cnt_s1 == pott_pkg::DAEMON_COUNT);
			end
			pott_pkg::CMD_RUN_FUSES: begin
				wr_cnt  = sel_match && !slot_cnt_s1[CNT_W-1] && (slot_cnt_s1 != '0);
				emit    = wr_cnt && (new_cnt == '0);
				clr_cls = emit;
			end
			default: begin
			end
		endcase
	end

	assign go = (state_q == S_EV) && (!emit || out_free);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						if (command > pott_pkg::CMD_RUN_FUSES) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					if (go) begin
						if (hit || idx_q == LAST_IDX) begin
							state_q <= S_FIN;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command capture and final status.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= command;
			id_q    <= action_id;
			arg_q   <= action_arg;
			turns_q <= turns;
			cls_q   <= slot_class;
			stat_q  <= pott_pkg::STAT_OK;
		end else if (go) begin
			if (hit) begin
				stat_q <= pott_pkg::STAT_OK;
			end else if (idx_q == LAST_IDX) begin
				stat_q <= miss_stat;
			end
		end
	end

	// Slot class flops, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				class_q[i] <= pott_pkg::CLASS_EMPTY;
			end
		end else if (go) begin
			if (wr_all) begin
				class_q[idx_q] <= cls_q;
			end else if (clr_cls) begin
				class_q[idx_q] <= pott_pkg::CLASS_EMPTY;
			end
		end
	end

	// Slot payload memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (go && wr_all) begin
			id_mem[idx_q]  <= id_q;
			arg_mem[idx_q] <= arg_q;
		end
		if (go && (wr_all || wr_cnt)) begin
			cnt_mem[idx_q] <= wr_cnt_val;
		end
		if (state_q == S_RD) begin
			slot_cls_s1 <= class_q[idx_q];
			slot_id_s1  <= id_mem[idx_q];
			slot_arg_s1 <= arg_mem[idx_q];
			slot_cnt_s1 <= cnt_mem[idx_q];
		end
	end

	// Result register: fired beats during the scan, the status beat at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((go && emit) || (state_q == S_FIN && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			out_kind_q <= pott_pkg::KIND_FIRED;
			out_stat_q <= pott_pkg::STAT_OK;
			out_id_q   <= slot_id_s1;
			out_arg_q  <= slot_arg_s1;
			out_last_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_kind_q <= pott_pkg::KIND_STATUS;
			out_stat_q <= stat_q;
			out_id_q   <= '0;
			out_arg_q  <= '0;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = out_kind_q;
	assign status      = out_stat_q;
	assign fired_id    = out_id_q;
	assign fired_arg   = out_arg_q;
	assign last        = out_last_q;

	// Checks on the sequencer and result ordering.
	`POTT_ASSERT_NEXT(a_accept_starts, clk, arst_n, accept, (state_q == S_RD) || (state_q == S_FIN), "accepted command did not start the sequencer")
	`POTT_ASSERT_NOW(a_fired_in_run, clk, arst_n, out_valid_q && (out_kind_q == pott_pkg::KIND_FIRED), (state_q != S_IDLE) && ((cmd_q == pott_pkg::CMD_RUN_DAEMONS) || (cmd_q == pott_pkg::CMD_RUN_FUSES)), "fired beat outside a run command")
	`POTT_ASSERT_NOW(a_idx_range, clk, arst_n, state_q != S_IDLE, idx_q <= LAST_IDX, "slot index beyond the table")

endmodule

// ----- bench/periodic_and_oneshot_timer_table_unit_test.sv -----
// Self-checking testbench for the timer table: predicts every result beat and checks it.
module periodic_and_oneshot_timer_table_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = pott_pkg::SLOTS_DEF;
	// Scan length of one command when the output does not stall.
	localparam int SCAN_CYCLES = 2 * SLOTS + 2;
	localparam int LONG_HOLD = 400;
	localparam int CYCLE_LIMIT = 400000;

	// Command codes with no function in the block.
	localparam logic [pott_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd6;
	localparam logic [pott_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd7;

	typedef struct packed {
		logic                        kind;
		logic [pott_pkg::STAT_W-1:0] status;
		logic [pott_pkg::ID_W-1:0]   fired_id;
		logic [pott_pkg::ARG_W-1:0]  fired_arg;
		logic                        last;
	} timer_result_t;

	logic                                clk;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_ready;
	logic [pott_pkg::CMD_W-1:0]          command;
	logic [pott_pkg::ID_W-1:0]           action_id;
	logic [pott_pkg::ARG_W-1:0]          action_arg;
	logic signed [pott_pkg::CNT_W-1:0]   turns;
	logic [pott_pkg::CLASS_W-1:0]        slot_class;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic                                result_kind;
	logic [pott_pkg::STAT_W-1:0]         status;
	logic [pott_pkg::ID_W-1:0]           fired_id;
	logic [pott_pkg::ARG_W-1:0]          fired_arg;
	logic                                last;

	// Shadow copy of the slot table.
	logic [pott_pkg::CLASS_W-1:0]      tbl_class [SLOTS] = '{default: '0};
	logic [pott_pkg::ID_W-1:0]         tbl_id    [SLOTS] = '{default: '0};
	logic [pott_pkg::ARG_W-1:0]        tbl_arg   [SLOTS] = '{default: '0};
	logic signed [pott_pkg::CNT_W-1:0] tbl_count [SLOTS] = '{default: '0};

	timer_result_t pending_results [$];
	int  error_count = 0;
	int  cycle_count = 0;
	int  hold_left = 0;
	int  burst_left = 0;
	bit  long_hold_req = 1'b0;
	bit  no_idle = 1'b0;

	periodic_and_oneshot_timer_table_unit #(.SLOTS(SLOTS)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.action_id  (action_id),
		.action_arg (action_arg),
		.turns      (turns),
		.slot_class (slot_class),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result_kind(result_kind),
		.status     (status),
		.fired_id   (fired_id),
		.fired_arg  (fired_arg),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Lowest empty slot, or -1 when the table is full.
	function automatic int first_free_slot();
		for (int i = 0; i < SLOTS; i++)
			if (tbl_class[i] == pott_pkg::CLASS_EMPTY)
				return i;
		return -1;
	endfunction

	// Lowest used slot holding the given id, or -1.
	function automatic int used_slot_with_id(logic [pott_pkg::ID_W-1:0] id);
		for (int i = 0; i < SLOTS; i++)
			if (tbl_class[i] != pott_pkg::CLASS_EMPTY && tbl_id[i] == id)
				return i;
		return -1;
	endfunction

	function automatic void push_fired(int s);
		timer_result_t res;
		res = '{kind: pott_pkg::KIND_FIRED, status: pott_pkg::STAT_OK, fired_id: tbl_id[s],
			fired_arg: tbl_arg[s], last: 1'b0};
		pending_results.push_back(res);
	endfunction

	// Applies one accepted command to the shadow table and queues its result beats.
	function automatic void apply_timer_command(logic [pott_pkg::CMD_W-1:0] cmd,
		logic [pott_pkg::ID_W-1:0] id, logic [pott_pkg::ARG_W-1:0] arg,
		logic signed [pott_pkg::CNT_W-1:0] trn, logic [pott_pkg::CLASS_W-1:0] cls);
		timer_result_t res;
		logic [pott_pkg::STAT_W-1:0] stat;
		int s;
		int sum;
		stat = pott_pkg::STAT_OK;
		case (cmd) inside
			pott_pkg::CMD_START_DAEMON, pott_pkg::CMD_START_FUSE: begin
				s = first_free_slot();
				if (s < 0) begin
					stat = pott_pkg::STAT_FULL;
				end else begin
					tbl_class[s] = cls;
					tbl_id[s] = id;
					tbl_arg[s] = arg;
					tbl_count[s] = (cmd == pott_pkg::CMD_START_DAEMON) ?
						pott_pkg::DAEMON_COUNT : trn;
				end
			end
			pott_pkg::CMD_LENGTHEN: begin
				s = used_slot_with_id(id);
				if (s < 0) begin
					stat = pott_pkg::STAT_NOT_FOUND;
				end else begin
					sum = int'(tbl_count[s]) + int'(trn);
					if (sum > 32767)
						sum = 32767;
					if (sum < -32768)
						sum = -32768;
					tbl_count[s] = pott_pkg::CNT_W'(sum);
				end
			end
			pott_pkg::CMD_CANCEL: begin
				s = used_slot_with_id(id);
				if (s < 0)
					stat = pott_pkg::STAT_NOT_FOUND;
				else
					tbl_class[s] = pott_pkg::CLASS_EMPTY;
			end
			pott_pkg::CMD_RUN_DAEMONS: begin
				if (cls != pott_pkg::CLASS_EMPTY)
					for (int i = 0; i < SLOTS; i++)
						if (tbl_class[i] == cls && tbl_count[i] == pott_pkg::DAEMON_COUNT)
							push_fired(i);
			end
			pott_pkg::CMD_RUN_FUSES: begin
				if (cls != pott_pkg::CLASS_EMPTY)
					for (int i = 0; i < SLOTS; i++) begin
						if (tbl_class[i] == cls && tbl_count[i] > 0) begin
							tbl_count[i] = tbl_count[i] - 1;
							if (tbl_count[i] == 0) begin
								tbl_class[i] = pott_pkg::CLASS_EMPTY;
								push_fired(i);
							end
						end
					end
			end
			default: begin
			end
		endcase
		res = '{kind: pott_pkg::KIND_STATUS, status: stat, fired_id: '0, fired_arg: '0,
			last: 1'b1};
		pending_results.push_back(res);
	endfunction

	// Offers one command beat, with an occasional idle gap first, and predicts it on acceptance.
	task automatic issue_command(logic [pott_pkg::CMD_W-1:0] cmd,
		logic [pott_pkg::ID_W-1:0] id, logic [pott_pkg::ARG_W-1:0] arg,
		logic signed [pott_pkg::CNT_W-1:0] trn, logic [pott_pkg::CLASS_W-1:0] cls);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		action_id <= id;
		action_arg <= arg;
		turns <= trn;
		slot_class <= cls;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		apply_timer_command(cmd, id, arg, trn, cls);
	endtask

	// Mostly ids from a small pool so lengthen and cancel find their slots.
	task automatic send_random_item();
		int pick;
		int t;
		logic [pott_pkg::CMD_W-1:0] cmd;
		logic [pott_pkg::ID_W-1:0] id;
		logic [pott_pkg::ARG_W-1:0] arg;
		logic signed [pott_pkg::CNT_W-1:0] trn;
		logic [pott_pkg::CLASS_W-1:0] cls;
		pick = $urandom_range(0, 99);
		id = ($urandom_range(0, 3) == 0) ? pott_pkg::ID_W'($urandom) :
			pott_pkg::ID_W'($urandom_range(0, 7));
		arg = pott_pkg::ARG_W'($urandom);
		cls = ($urandom_range(0, 9) == 0) ? pott_pkg::CLASS_EMPTY :
			pott_pkg::CLASS_W'($urandom_range(1, 3));
		if (pick < 14)
			cmd = pott_pkg::CMD_START_DAEMON;
		else if (pick < 34)
			cmd = pott_pkg::CMD_START_FUSE;
		else if (pick < 44)
			cmd = pott_pkg::CMD_LENGTHEN;
		else if (pick < 58)
			cmd = pott_pkg::CMD_CANCEL;
		else if (pick < 76)
			cmd = pott_pkg::CMD_RUN_DAEMONS;
		else if (pick < 96)
			cmd = pott_pkg::CMD_RUN_FUSES;
		else if (pick < 98)
			cmd = CMD_SPARE_A;
		else
			cmd = CMD_SPARE_B;
		pick = $urandom_range(0, 19);
		if (pick < 14) begin
			if (cmd == pott_pkg::CMD_START_FUSE)
				t = $urandom_range(1, 4);
			else
				t = int'($urandom_range(0, 6)) - 3;
			trn = pott_pkg::CNT_W'(t);
		end else if (pick < 17) begin
			trn = pott_pkg::CNT_W'($urandom);
		end else begin
			case ($urandom_range(0, 3))
				0: trn = 16'sd0;
				1: trn = -16'sd1;
				2: trn = 16'sh7FFF;
				default: trn = 16'sh8000;
			endcase
		end
		issue_command(cmd, id, arg, trn, cls);
	endtask

	// Cancels the lowest used slot until the table is empty.
	task automatic clear_table();
		int s;
		s = 0;
		while (s >= 0) begin
			s = -1;
			for (int i = SLOTS - 1; i >= 0; i--)
				if (tbl_class[i] != pott_pkg::CLASS_EMPTY)
					s = i;
			if (s >= 0)
				issue_command(pott_pkg::CMD_CANCEL, tbl_id[s], pott_pkg::ARG_W'($urandom),
					16'sd0, 2'd1);
		end
	endtask

	// Output ready: random stall and run bursts, a long hold on request, or always ready.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = LONG_HOLD - 1;
			out_ready <= 1'b0;
		end else if (no_idle) begin
			out_ready <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left--;
		end else if ($urandom_range(0, 2) == 0) begin
			out_ready <= 1'b0;
			burst_left = $urandom_range(1, 16) - 1;
		end else begin
			out_ready <= 1'b1;
			burst_left = $urandom_range(1, 24) - 1;
		end
	end

	function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endfunction

	// Each accepted result beat is checked against the oldest prediction.
	always @(posedge clk) begin : result_check
		timer_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat: kind %0h status %0h id %0h",
					$time, result_kind, status, fired_id);
				$display("%0t: unexpected result beat: arg %0h last %0h",
					$time, fired_arg, last);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("result_kind", 16'(want.kind), 16'(result_kind));
				compare_field("status", 16'(want.status), 16'(status));
				compare_field("fired_id", 16'(want.fired_id), 16'(fired_id));
				compare_field("fired_arg", want.fired_arg, fired_arg);
				compare_field("last", 16'(want.last), 16'(last));
			end
		end
	end

	// Commands on an empty table: not found, run with nothing to fire, unused codes.
	task automatic test_empty_table();
		issue_command(pott_pkg::CMD_CANCEL, 6'd0, 16'h0000, 16'sd0, 2'd0);
		issue_command(pott_pkg::CMD_LENGTHEN, 6'd63, 16'hFFFF, 16'sh7FFF, 2'd3);
		issue_command(pott_pkg::CMD_RUN_DAEMONS, 6'd0, 16'h0000, 16'sd0, 2'd1);
		issue_command(pott_pkg::CMD_RUN_FUSES, 6'd0, 16'h0000, 16'sd0, 2'd3);
		issue_command(CMD_SPARE_A, 6'd0, 16'h0000, 16'sd0, 2'd0);
		issue_command(CMD_SPARE_B, 6'd63, 16'hFFFF, -16'sd1, 2'd3);
	endtask

	// Daemons, fuses with edge counts, a start with class zero and runs of every class.
	task automatic test_start_kinds();
		issue_command(pott_pkg::CMD_START_DAEMON, 6'd63, 16'hFFFF, 16'sh8000, 2'd3);
		issue_command(pott_pkg::CMD_START_DAEMON, 6'd9, 16'h1234, 16'sd0, 2'd0);
		issue_command(pott_pkg::CMD_START_FUSE, 6'd0, 16'h0000, 16'sd1, 2'd1);
		issue_command(pott_pkg::CMD_START_FUSE, 6'd5, 16'h5555, 16'sd0, 2'd1);
		issue_command(pott_pkg::CMD_START_FUSE, 6'd6, 16'hAAAA, -16'sd1, 2'd2);
		issue_command(pott_pkg::CMD_START_FUSE, 6'd7, 16'h0F0F, 16'sh8000, 2'd2);
		issue_command(pott_pkg::CMD_RUN_DAEMONS, 6'd0, 16'h0000, 16'sd0, 2'd3);
		issue_command(pott_pkg::CMD_RUN_DAEMONS, 6'd0, 16'h0000, 16'sd0, 2'd2);
		issue_command(pott_pkg::CMD_RUN_FUSES, 6'd0, 16'h0000, 16'sd0, 2'd1);
		issue_command(pott_pkg::CMD_RUN_DAEMONS, 6'd63, 16'hFFFF, 16'sd0, 2'd0);
		issue_command(pott_pkg::CMD_RUN_FUSES, 6'd63, 16'hFFFF, 16'sd0, 2'd0);
	endtask

	// Saturation at both ends, a lengthened daemon turning into a fuse, and cancel.
	task automatic test_lengthen_cancel();
		issue_command(pott_pkg::CMD_START_FUSE, 6'd10, 16'hBEEF, 16'sh7FFF, 2'd1);
		issue_command(pott_pkg::CMD_LENGTHEN, 6'd10, 16'h0000, 16'sh7FFF, 2'd0);
		issue_command(pott_pkg::CMD_LENGTHEN, 6'd7, 16'h0000, 16'sh8000, 2'd0);
		issue_command(pott_pkg::CMD_LENGTHEN, 6'd63, 16'h0000, 16'sd2, 2'd0);
		issue_command(pott_pkg::CMD_RUN_FUSES, 6'd0, 16'h0000, 16'sd0, 2'd3);
		issue_command(pott_pkg::CMD_RUN_DAEMONS, 6'd0, 16'h0000, 16'sd0, 2'd3);
		issue_command(pott_pkg::CMD_CANCEL, 6'd10, 16'h0000, 16'sd0, 2'd0);
		issue_command(pott_pkg::CMD_CANCEL, 6'd10, 16'h0000, 16'sd0, 2'd0);
	endtask

	// Full table: starts that are refused, then runs that fire every slot at once.
	task automatic test_table_full();
		clear_table();
		for (int i = 0; i < SLOTS; i++)
			issue_command(pott_pkg::CMD_START_FUSE, pott_pkg::ID_W'($urandom),
				pott_pkg::ARG_W'($urandom), 16'sd1, 2'd1);
		issue_command(pott_pkg::CMD_START_DAEMON, 6'd1, 16'h1111, 16'sd0, 2'd2);
		issue_command(pott_pkg::CMD_START_FUSE, 6'd2, 16'h2222, 16'sd3, 2'd2);
		issue_command(pott_pkg::CMD_RUN_DAEMONS, 6'd0, 16'h0000, 16'sd0, 2'd1);
		issue_command(pott_pkg::CMD_RUN_FUSES, 6'd0, 16'h0000, 16'sd0, 2'd1);
		for (int i = 0; i < SLOTS; i++)
			issue_command(pott_pkg::CMD_START_DAEMON, pott_pkg::ID_W'($urandom_range(0, 7)),
				pott_pkg::ARG_W'($urandom), pott_pkg::CNT_W'($urandom), 2'd2);
		issue_command(pott_pkg::CMD_RUN_DAEMONS, 6'd0, 16'h0000, 16'sd0, 2'd2);
		clear_table();
	endtask

	task automatic test_random_traffic(int count);
		repeat (count)
			send_random_item();
	endtask

	// The receiver stops for a long stretch while daemon runs keep arriving.
	task automatic test_output_backpressure();
		repeat (3)
			issue_command(pott_pkg::CMD_START_DAEMON, pott_pkg::ID_W'($urandom),
				pott_pkg::ARG_W'($urandom), 16'sd0, 2'd3);
		long_hold_req = 1'b1;
		repeat (10)
			issue_command(pott_pkg::CMD_RUN_DAEMONS, pott_pkg::ID_W'($urandom),
				pott_pkg::ARG_W'($urandom), 16'sd0, 2'd3);
	endtask

	// Back-to-back traffic with no idle gaps and the output always ready.
	task automatic test_steady_stream(int count);
		no_idle = 1'b1;
		repeat (count)
			send_random_item();
	endtask

	// Drains every expected beat, lets the block settle and reports the outcome.
	task automatic finish_run();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SCAN_CYCLES + 8) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = '0;
		action_id = '0;
		action_arg = '0;
		turns = '0;
		slot_class = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_start_kinds();
		test_lengthen_cancel();
		test_table_full();
		test_random_traffic(60);
		test_output_backpressure();
		test_random_traffic(50);
		test_steady_stream(25);
		finish_run();
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/pott_pkg.sv
rtl/core/periodic_and_oneshot_timer_table_unit.sv
bench/periodic_and_oneshot_timer_table_unit_test.sv
